@@ hdl/eased_vector_interpolator_unit_assert.svh @@
// Assertion macros shared by the eased vector interpolator RTL.
`ifndef EASED_VECTOR_INTERPOLATOR_UNIT_ASSERT_SVH
`define EASED_VECTOR_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication on clk_i, disabled during reset.
`define EVI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication on clk_i, disabled during reset.
`define EVI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EVI_ASSERT_IMP(lbl, ante, cons, msg)
`define EVI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/evi_pkg.sv @@
// Shared types, constants and curve tables of the eased vector interpolator.
package evi_pkg;

  localparam int LANES        = 3;
  localparam int NUM_COMP     = 3;
  localparam int FRAC_BITS    = 16;
  localparam int YW           = FRAC_BITS + 1;
  localparam int VAL_W        = 32;
  localparam int EL_W         = 16;
  localparam int DUR_W        = 15;
  localparam int CNT_W        = 2;
  localparam int DIV_STEPS    = FRAC_BITS;
  localparam int SIN_SEG_BITS = FRAC_BITS - 5;
  localparam int EXP_SEG_BITS = FRAC_BITS - 4;
  localparam int LATENCY      = DIV_STEPS + 4;

  localparam logic [YW-1:0] ONE  = YW'(1) << FRAC_BITS;
  localparam logic [YW-1:0] HALF = YW'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    OP_LINEAR     = 3'd0,
    OP_SIN_IN     = 3'd1,
    OP_SIN_OUT    = 3'd2,
    OP_SIN_INOUT  = 3'd3,
    OP_QUAD_IN    = 3'd4,
    OP_QUAD_OUT   = 3'd5,
    OP_QUAD_INOUT = 3'd6,
    OP_EXPO_OUT   = 3'd7
  } ease_op_e;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_TARGET,
    MODE_INTERP
  } mode_e;

  typedef struct packed {
    ease_op_e                        op;
    mode_e                           mode;
    logic [CNT_W-1:0]                cnt;
    logic [LANES-1:0][VAL_W-1:0]     start;
    logic [LANES-1:0][VAL_W-1:0]     target;
  } side_t;

  // Quarter sine, sin(k*pi/64) in Q1.16
  function automatic logic [16:0] sine_at(input logic [5:0] idx);
    logic [16:0] v;
    unique case (idx)
      6'd0:  v = 17'd0;     6'd1:  v = 17'd3216;  6'd2:  v = 17'd6424;
      6'd3:  v = 17'd9616;  6'd4:  v = 17'd12785; 6'd5:  v = 17'd15924;
      6'd6:  v = 17'd19024; 6'd7:  v = 17'd22078; 6'd8:  v = 17'd25080;
      6'd9:  v = 17'd28020; 6'd10: v = 17'd30893; 6'd11: v = 17'd33692;
      6'd12: v = 17'd36410; 6'd13: v = 17'd39040; 6'd14: v = 17'd41576;
      6'd15: v = 17'd44011; 6'd16: v = 17'd46341; 6'd17: v = 17'd48559;
      6'd18: v = 17'd50660; 6'd19: v = 17'd52639; 6'd20: v = 17'd54491;
      6'd21: v = 17'd56212; 6'd22: v = 17'd57798; 6'd23: v = 17'd59244;
      6'd24: v = 17'd60547; 6'd25: v = 17'd61705; 6'd26: v = 17'd62714;
      6'd27: v = 17'd63572; 6'd28: v = 17'd64277; 6'd29: v = 17'd64827;
      6'd30: v = 17'd65220; 6'd31: v = 17'd65457; 6'd32: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // 2^(-k/16) in Q1.16
  function automatic logic [16:0] exp_at(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:  v = 17'd65536; 5'd1:  v = 17'd62757; 5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549; 5'd4:  v = 17'd55109; 5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535; 5'd7:  v = 17'd48393; 5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376; 5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
      5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
      5'd15: v = 17'd34219; 5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/evi_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, sideband alongside.
module evi_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [evi_pkg::DUR_W-1:0]      rem_i,
  input  logic [evi_pkg::DUR_W-1:0]      dvs_i,
  input  evi_pkg::side_t                 side_i,
  output logic                           valid_o,
  output logic [evi_pkg::FRAC_BITS-1:0]  quot_o,
  output evi_pkg::side_t                 side_o
);

  localparam int N  = evi_pkg::DIV_STEPS;
  localparam int RW = evi_pkg::DUR_W;
  localparam int QW = evi_pkg::FRAC_BITS;

  logic [N-1:0]   vld_q;
  logic [RW-1:0]  rem_q  [N];
  logic [RW-1:0]  dvs_q  [N];
  logic [QW-1:0]  quot_q [N];
  evi_pkg::side_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : gen_step
    logic           v_in;
    logic [RW-1:0]  rem_in;
    logic [RW-1:0]  dvs_in;
    logic [QW-1:0]  q_in;
    evi_pkg::side_t s_in;
    logic [RW:0]    shl;
    logic [RW:0]    sub;
    logic           ge;

    // Take the stage inputs from the ports or the stage before
    if (k == 0) begin : gen_first
      assign v_in   = valid_i;
      assign rem_in = rem_i;
      assign dvs_in = dvs_i;
      assign q_in   = '0;
      assign s_in   = side_i;
    end else begin : gen_next
      assign v_in   = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign q_in   = quot_q[k-1];
      assign s_in   = side_q[k-1];
    end

    // Shift in a zero numerator bit and trial-subtract the divisor
    assign shl = {rem_in, 1'b0};
    assign sub = shl - {1'b0, dvs_in};
    assign ge  = (shl >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? sub[RW-1:0] : shl[RW-1:0];
      dvs_q[k]  <= dvs_in;
      quot_q[k] <= {q_in[QW-2:0], ge};
      side_q[k] <= s_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quot_o  = quot_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

@@ hdl/evi_ease.sv @@
// Two-stage easing curve unit: table lookups and products, then combine.
module evi_ease (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [evi_pkg::FRAC_BITS-1:0]  x_i,
  input  evi_pkg::side_t                 side_i,
  output logic                           valid_o,
  output logic [evi_pkg::YW-1:0]         y_o,
  output evi_pkg::side_t                 side_o
);

  localparam int F    = evi_pkg::FRAC_BITS;
  localparam int YW   = evi_pkg::YW;
  localparam int SSB  = evi_pkg::SIN_SEG_BITS;
  localparam int ESB  = evi_pkg::EXP_SEG_BITS;
  localparam int SIW  = YW - SSB;
  localparam int SPW  = YW + SSB;
  localparam int EPW  = YW + ESB;
  localparam int TW   = YW + 4;
  localparam int WW   = YW + F + 1;
  localparam logic [YW-1:0] ONE  = evi_pkg::ONE;
  localparam logic [YW-1:0] HALF = evi_pkg::HALF;

  // Stage A: arguments, table reads and products
  logic [YW-1:0]   x_w;
  logic            lo;
  logic [YW:0]     twox;
  logic [YW-1:0]   p_lo;
  logic [YW:0]     p_hi;
  logic [YW-1:0]   p;
  logic [SIW-1:0]  si;
  logic [SSB-1:0]  sfr;
  logic [16:0]     sbase;
  logic [16:0]     sdiff;
  logic [SPW-1:0]  sprod;
  logic [YW-1:0]   u;
  logic [2*YW-1:0] sq;
  logic [TW-1:0]   t10;
  logic [3:0]      n_raw;
  logic [3:0]      n_cl;
  logic [F-1:0]    ef;
  logic [3:0]      ei;
  logic [ESB-1:0]  efr;
  logic [16:0]     ebase;
  logic [16:0]     ediff;
  logic [EPW-1:0]  eprod;

  always_comb begin
    x_w  = {1'b0, x_i};
    lo   = (x_w < HALF);
    twox = {x_w, 1'b0};
    p_lo = ONE - twox[YW-1:0];
    p_hi = twox - {1'b0, ONE};
    unique case (side_i.op)
      evi_pkg::OP_SIN_IN:    p = ONE - x_w;
      evi_pkg::OP_SIN_INOUT: p = lo ? p_lo : p_hi[YW-1:0];
      default:               p = x_w;
    endcase
    si    = p[YW-1:SSB];
    sfr   = p[SSB-1:0];
    sbase = evi_pkg::sine_at(6'(si));
    sdiff = evi_pkg::sine_at(6'(si) + 6'd1) - sbase;
    sprod = SPW'(sdiff) * SPW'(sfr);

    if (side_i.op == evi_pkg::OP_QUAD_IN ||
        (side_i.op == evi_pkg::OP_QUAD_INOUT && lo)) begin
      u = x_w;
    end else begin
      u = ONE - x_w;
    end
    sq = (2*YW)'(u) * (2*YW)'(u);

    t10   = {x_w, 3'b000} + {2'b00, x_w, 1'b0};
    n_raw = t10[F+3:F];
    n_cl  = (n_raw > 4'd9) ? 4'd9 : n_raw;
    ef    = t10[F-1:0];
    ei    = ef[F-1:ESB];
    efr   = ef[ESB-1:0];
    ebase = evi_pkg::exp_at({1'b0, ei});
    ediff = ebase - evi_pkg::exp_at({1'b0, ei} + 5'd1);
    eprod = EPW'(ediff) * EPW'(efr);
  end

  logic            a_vld_q;
  evi_pkg::side_t  a_side_q;
  logic [YW-1:0]   a_x_q;
  logic            a_lo_q;
  logic            a_sat_q;
  logic [16:0]     a_sbase_q;
  logic [SPW-1:0]  a_sprod_q;
  logic [2*YW-1:0] a_sq_q;
  logic [3:0]      a_n_q;
  logic [16:0]     a_ebase_q;
  logic [EPW-1:0]  a_eprod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q  <= side_i;
    a_x_q     <= x_w;
    a_lo_q    <= lo;
    a_sat_q   <= si[SIW-1];
    a_sbase_q <= sbase;
    a_sprod_q <= sprod;
    a_sq_q    <= sq;
    a_n_q     <= n_cl;
    a_ebase_q <= ebase;
    a_eprod_q <= eprod;
  end

  // Stage B: finish the curves, clamp and apply the mode
  logic [YW-1:0] sv;
  logic [WW-1:0] sfull;
  logic [YW-1:0] s_val;
  logic [YW:0]   s_hi;
  logic [YW-1:0] s_lo;
  logic [YW:0]   q16;
  logic [YW:0]   q15;
  logic [16:0]   ev;
  logic [WW-1:0] esum;
  logic [WW-1:0] eshr;
  logic [YW:0]   yr;
  logic [YW-1:0] yc;
  logic [YW-1:0] y_d;

  always_comb begin
    sv    = a_sat_q ? ONE : a_sbase_q + YW'(a_sprod_q >> SSB);
    sfull = {1'b0, sv, {F{1'b0}}} + WW'(1 << 15);
    s_val = sfull[16 +: YW];
    s_hi  = {1'b0, ONE} + {1'b0, s_val};
    s_lo  = ONE - s_val;
    q16   = (YW+1)'(a_sq_q >> F);
    q15   = (YW+1)'(a_sq_q >> (F - 1));
    ev    = a_ebase_q - 17'(a_eprod_q >> ESB);
    esum  = {1'b0, ev, {F{1'b0}}} + (WW'(1) << (5'(a_n_q) + 5'd15));
    eshr  = esum >> (5'(a_n_q) + 5'd16);

    unique case (a_side_q.op)
      evi_pkg::OP_LINEAR:     yr = {1'b0, a_x_q};
      evi_pkg::OP_SIN_IN:     yr = {1'b0, s_lo};
      evi_pkg::OP_SIN_OUT:    yr = {1'b0, s_val};
      evi_pkg::OP_SIN_INOUT:  yr = a_lo_q ? {2'b00, s_lo[YW-1:1]} : {1'b0, s_hi[YW:1]};
      evi_pkg::OP_QUAD_IN:    yr = q16;
      evi_pkg::OP_QUAD_OUT:   yr = {1'b0, ONE} - q16;
      evi_pkg::OP_QUAD_INOUT: yr = a_lo_q ? q15 : {1'b0, ONE} - q15;
      evi_pkg::OP_EXPO_OUT:   yr = {1'b0, ONE} - (YW+1)'(eshr);
      default:                yr = {1'b0, a_x_q};
    endcase
    yc = (yr > {1'b0, ONE}) ? ONE : yr[YW-1:0];

    unique case (a_side_q.mode)
      evi_pkg::MODE_START:  y_d = '0;
      evi_pkg::MODE_TARGET: y_d = ONE;
      evi_pkg::MODE_INTERP: y_d = yc;
      default:              y_d = '0;
    endcase
  end

  logic b_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y_o    <= y_d;
    side_o <= a_side_q;
  end

  assign valid_o = b_vld_q;

endmodule

@@ hdl/evi_lane.sv @@
// One interpolation lane: registered weight product, then round and add.
module evi_lane (
  input  logic                        clk_i,
  input  logic [evi_pkg::YW-1:0]      y_i,
  input  logic [evi_pkg::VAL_W-1:0]   start_i,
  input  logic [evi_pkg::VAL_W-1:0]   target_i,
  input  evi_pkg::mode_e              mode_i,
  output logic [evi_pkg::VAL_W-1:0]   value_o
);

  localparam int F  = evi_pkg::FRAC_BITS;
  localparam int VW = evi_pkg::VAL_W;
  localparam int PW = VW + 1 + evi_pkg::YW + 1;

  logic signed [VW:0]   diff;
  logic signed [PW-1:0] prod_d;

  // Multiply the weight by target minus start
  always_comb begin
    diff   = $signed({target_i[VW-1], target_i}) - $signed({start_i[VW-1], start_i});
    prod_d = PW'(diff) * PW'($signed({1'b0, y_i}));
  end

  logic signed [PW-1:0] prod_q;
  logic [VW-1:0]        s_q;
  logic [VW-1:0]        t_q;
  evi_pkg::mode_e       mode_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    s_q    <= start_i;
    t_q    <= target_i;
    mode_q <= mode_i;
  end

  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shr;
  logic [VW-1:0]        lerp;

  // Round half up, floor-shift, add to start, then pick start, target or lerp by mode
  always_comb begin
    rnd  = prod_q + $signed(PW'(evi_pkg::HALF));
    shr  = rnd >>> F;
    lerp = s_q + shr[VW-1:0];
    unique case (mode_q)
      evi_pkg::MODE_START:  value_o = s_q;
      evi_pkg::MODE_TARGET: value_o = t_q;
      evi_pkg::MODE_INTERP: value_o = lerp;
      default:              value_o = '0;
    endcase
  end

endmodule

@@ hdl/eased_vector_interpolator_unit.sv @@
// Eased vector interpolator top level: divider, easing unit, lanes and merge.
// Pipeline from the start transfer to the valid_o strobe: 16 divider stages,
// 2 easing stages, 1 lane product stage and 1 merge register.
// Throughput: one item per cycle; busy_o stays low, the pipeline never stalls.
// Each result shows on the outputs for one cycle with valid_o high.
// Reset clears all valid bits asynchronously; payload registers are not reset.
`include "eased_vector_interpolator_unit_assert.svh"
module eased_vector_interpolator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [2:0]                    op_i,
  input  logic signed [15:0]            elapsed_ticks_i,
  input  logic [14:0]                   duration_ticks_i,
  input  logic [1:0]                    component_count_i,
  input  logic signed [31:0]            start_x_i,
  input  logic signed [31:0]            start_y_i,
  input  logic signed [31:0]            start_z_i,
  input  logic signed [31:0]            target_x_i,
  input  logic signed [31:0]            target_y_i,
  input  logic signed [31:0]            target_z_i,
  output logic                          valid_o,
  output logic signed [31:0]            value_x_o,
  output logic signed [31:0]            value_y_o,
  output logic signed [31:0]            value_z_o,
  output logic [evi_pkg::YW-1:0]        eased_fraction_o
);

  localparam int L  = evi_pkg::LANES;
  localparam int NC = evi_pkg::NUM_COMP;
  localparam int VW = evi_pkg::VAL_W;
  localparam int YW = evi_pkg::YW;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Classify the item and build the divider operands
  logic [NC-1:0][VW-1:0]        s_all;
  logic [NC-1:0][VW-1:0]        t_all;
  evi_pkg::side_t               side_in;
  logic [evi_pkg::DUR_W-1:0]    rem_in;

  assign s_all = {start_z_i, start_y_i, start_x_i};
  assign t_all = {target_z_i, target_y_i, target_x_i};

  always_comb begin
    side_in.op  = evi_pkg::ease_op_e'(op_i);
    side_in.cnt = component_count_i;
    for (int k = 0; k < L; k++) begin
      side_in.start[k]  = s_all[k];
      side_in.target[k] = t_all[k];
    end
    rem_in = '0;
    if (elapsed_ticks_i[15] || elapsed_ticks_i == '0) begin
      side_in.mode = evi_pkg::MODE_START;
    end else if (elapsed_ticks_i[14:0] >= duration_ticks_i) begin
      side_in.mode = evi_pkg::MODE_TARGET;
    end else begin
      side_in.mode = evi_pkg::MODE_INTERP;
      rem_in       = elapsed_ticks_i[14:0];
    end
  end

  logic                            div_vld;
  logic [evi_pkg::FRAC_BITS-1:0]   div_quot;
  evi_pkg::side_t                  div_side;

  evi_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .rem_i   (rem_in),
    .dvs_i   (duration_ticks_i),
    .side_i  (side_in),
    .valid_o (div_vld),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  logic           ease_vld;
  logic [YW-1:0]  ease_y;
  evi_pkg::side_t ease_side;

  evi_ease u_ease (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_vld),
    .x_i     (div_quot),
    .side_i  (div_side),
    .valid_o (ease_vld),
    .y_o     (ease_y),
    .side_o  (ease_side)
  );

  // Track valid, weight, count and mode alongside the lane product stage
  logic                     lane_vld_q;
  logic [YW-1:0]            lane_y_q;
  logic [evi_pkg::CNT_W-1:0] lane_cnt_q;
  evi_pkg::mode_e           lane_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
    end else begin
      lane_vld_q <= ease_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_y_q    <= ease_y;
    lane_cnt_q  <= ease_side.cnt;
    lane_mode_q <= ease_side.mode;
  end

  logic [L-1:0][VW-1:0] lane_val;

  for (genvar k = 0; k < L; k++) begin : gen_lane
    evi_lane u_lane (
      .clk_i    (clk_i),
      .y_i      (ease_y),
      .start_i  (ease_side.start[k]),
      .target_i (ease_side.target[k]),
      .mode_i   (ease_side.mode),
      .value_o  (lane_val[k])
    );
  end

  // Merge: zero the lanes beyond the component count
  logic [NC-1:0][VW-1:0] comp_val;

  for (genvar k = 0; k < NC; k++) begin : gen_comp
    if (k < L) begin : gen_used
      assign comp_val[k] = (evi_pkg::CNT_W'(k) < lane_cnt_q) ? lane_val[k] : '0;
    end else begin : gen_unused
      assign comp_val[k] = '0;
    end
  end

  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= lane_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_x_o        <= comp_val[0];
    value_y_o        <= comp_val[1];
    value_z_o        <= comp_val[2];
    eased_fraction_o <= lane_y_q;
  end

  assign valid_o = out_vld_q;

  `EVI_ASSERT_IMP(a_frac_range, valid_o, eased_fraction_o <= evi_pkg::ONE, "weight above one")
  `EVI_ASSERT_NXT(a_start_zero, lane_vld_q && lane_mode_q == evi_pkg::MODE_START, eased_fraction_o == '0, "start item weight not zero")
  `EVI_ASSERT_NXT(a_target_one, lane_vld_q && lane_mode_q == evi_pkg::MODE_TARGET, eased_fraction_o == evi_pkg::ONE, "target item weight not one")
  `EVI_ASSERT_NXT(a_cnt_zero, lane_vld_q && lane_cnt_q == '0, value_x_o == '0 && value_y_o == '0 && value_z_o == '0, "unused lanes not zero")

endmodule

@@ tb/sv/eased_vector_interpolator_unit_tb.sv @@
// Self-checking testbench of the eased vector interpolator unit.
module eased_vector_interpolator_unit_tb;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] el;
    logic [14:0]        du;
    logic [1:0]         cnt;
    logic signed [31:0] s [3];
    logic signed [31:0] t [3];
  } tween_t;

  typedef struct {
    logic signed [31:0]        v [3];
    logic [evi_pkg::YW-1:0]    frac;
  } lerp_t;

  localparam longint ONE_L = 64'd1 << evi_pkg::FRAC_BITS;

  function automatic longint sine_tab_val(longint i);
    longint tab [33] = '{0, 3216, 6424, 9616, 12785, 15924, 19024, 22078,
      25080, 28020, 30893, 33692, 36410, 39040, 41576, 44011, 46341, 48559,
      50660, 52639, 54491, 56212, 57798, 59244, 60547, 61705, 62714, 63572,
      64277, 64827, 65220, 65457, 65536};
    return tab[i];
  endfunction

  // Quarter sine of p in Q1.16, table interpolated
  function automatic longint quarter_sine(longint p);
    longint i, fr, v;
    if (p > ONE_L) p = ONE_L;
    i = p >> evi_pkg::SIN_SEG_BITS;
    if (i >= 32) v = 65536;
    else begin
      fr = p & ((64'd1 << evi_pkg::SIN_SEG_BITS) - 1);
      v = sine_tab_val(i) +
          (((sine_tab_val(i + 1) - sine_tab_val(i)) * fr) >> evi_pkg::SIN_SEG_BITS);
    end
    return (v * ONE_L + 32768) >> 16;
  endfunction

  function automatic longint expo_curve(longint x);
    longint tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
      48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    longint t, n, f, i, fr, e, sh;
    t = 10 * x;
    n = t >> evi_pkg::FRAC_BITS;
    f = t & (ONE_L - 1);
    i = f >> evi_pkg::EXP_SEG_BITS;
    fr = f & ((64'd1 << evi_pkg::EXP_SEG_BITS) - 1);
    if (n > 9) n = 9;
    e = tab[i] - (((tab[i] - tab[i + 1]) * fr) >> evi_pkg::EXP_SEG_BITS);
    sh = 16 + n;
    return ONE_L - ((e * ONE_L + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint eased_weight(evi_pkg::ease_op_e op, longint x);
    longint u;
    case (op)
      evi_pkg::OP_SIN_IN:    return ONE_L - quarter_sine(ONE_L - x);
      evi_pkg::OP_SIN_OUT:   return quarter_sine(x);
      evi_pkg::OP_SIN_INOUT: begin
        if (x < ONE_L / 2) return (ONE_L - quarter_sine(ONE_L - 2 * x)) >> 1;
        return (ONE_L + quarter_sine(2 * x - ONE_L)) >> 1;
      end
      evi_pkg::OP_QUAD_IN:   return (x * x) >> evi_pkg::FRAC_BITS;
      evi_pkg::OP_QUAD_OUT:  begin
        u = ONE_L - x;
        return ONE_L - ((u * u) >> evi_pkg::FRAC_BITS);
      end
      evi_pkg::OP_QUAD_INOUT: begin
        if (x < ONE_L / 2) return (2 * x * x) >> evi_pkg::FRAC_BITS;
        u = ONE_L - x;
        return ONE_L - ((2 * u * u) >> evi_pkg::FRAC_BITS);
      end
      evi_pkg::OP_EXPO_OUT:  return expo_curve(x);
      default:               return x;
    endcase
  endfunction

  function automatic lerp_t predict_lerp(tween_t tw);
    lerp_t r;
    longint y, x, prod, v, sv, tv;
    int mode;
    if (tw.el <= 0) begin
      mode = 0; y = 0;
    end else if (longint'(tw.el) >= longint'(tw.du)) begin
      mode = 1; y = ONE_L;
    end else begin
      x = (longint'(tw.el) << evi_pkg::FRAC_BITS) / longint'(tw.du);
      mode = 2;
      y = eased_weight(evi_pkg::ease_op_e'(tw.op), x);
      if (y > ONE_L) y = ONE_L;
    end
    for (int k = 0; k < 3; k++) begin
      sv = tw.s[k];
      tv = tw.t[k];
      if (k >= tw.cnt || k >= evi_pkg::LANES) v = 0;
      else if (mode == 0) v = sv;
      else if (mode == 1) v = tv;
      else begin
        prod = y * (tv - sv) + ONE_L / 2;
        v = sv + (prod >>> evi_pkg::FRAC_BITS);
      end
      r.v[k] = v[31:0];
    end
    r.frac = y[evi_pkg::YW-1:0];
    return r;
  endfunction

  // Scoreboard of expected interpolations
  class lerp_scoreboard;
    lerp_t pending [$];
    int    errors;
    int    checked;

    function void note_tween(tween_t tw);
      pending.push_back(predict_lerp(tw));
    endfunction

    function void check_lerp(lerp_t got);
      lerp_t exp_r;
      string names [3] = '{"value_x", "value_y", "value_z"};
      if (pending.size() == 0) begin
        $error("result with no transfer outstanding");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      for (int k = 0; k < 3; k++)
        if (got.v[k] !== exp_r.v[k]) begin
          $error("%s expected %0d actual %0d", names[k], exp_r.v[k], got.v[k]);
          errors++;
        end
      if (got.frac !== exp_r.frac) begin
        $error("eased_fraction expected %0d actual %0d", exp_r.frac, got.frac);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0, start_i = 1'b0;
  logic busy_o, valid_o;
  logic [2:0] op_i = '0;
  logic signed [15:0] elapsed_ticks_i = '0;
  logic [14:0] duration_ticks_i = '0;
  logic [1:0] component_count_i = '0;
  logic signed [31:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] value_x_o, value_y_o, value_z_o;
  logic [evi_pkg::YW-1:0] eased_fraction_o;

  lerp_scoreboard sb = new();
  int idle_pct;
  longint cycles = 0;

  eased_vector_interpolator_unit u_dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Check each strobed result
  always @(posedge clk_i) begin
    lerp_t got;
    cycles <= cycles + 1;
    if (rst_ni && valid_o) begin
      got.v[0] = value_x_o; got.v[1] = value_y_o; got.v[2] = value_z_o;
      got.frac = eased_fraction_o;
      sb.check_lerp(got);
    end
  end

  // Watchdog
  initial begin
    wait (cycles > 200000);
    $display("TB_ERROR");
    $finish;
  end

  // Transfer one tween, with optional idle cycles ahead of it
  task automatic send_tween(tween_t tw);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i           <= 1'b1;
    op_i              <= tw.op;
    elapsed_ticks_i   <= tw.el;
    duration_ticks_i  <= tw.du;
    component_count_i <= tw.cnt;
    start_x_i <= tw.s[0]; start_y_i <= tw.s[1]; start_z_i <= tw.s[2];
    target_x_i <= tw.t[0]; target_y_i <= tw.t[1]; target_z_i <= tw.t[2];
    do @(posedge clk_i); while (busy_o);
    sb.note_tween(tw);
  endtask

  function automatic tween_t random_tween();
    tween_t tw;
    tw.op = 3'($urandom_range(7));
    tw.du = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(200));
    case ($urandom_range(9))
      0:       tw.el = 16'($urandom);
      1:       tw.el = -16'($urandom_range(5));
      2:       tw.el = 16'(tw.du + $urandom_range(3));
      default: tw.el = (tw.du > 1) ? 16'($urandom_range(tw.du - 1, 1)) : 16'sd1;
    endcase
    tw.cnt = 2'($urandom_range(3));
    for (int k = 0; k < 3; k++) begin
      tw.s[k] = $urandom;
      tw.t[k] = ($urandom_range(1)) ? $urandom :
                32'(tw.s[k] + $urandom_range(200) - 100);
    end
    return tw;
  endfunction

  initial begin
    tween_t tw;
    int phase_idle [4] = '{0, 68, 0, 33};
    idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: every curve mid-way, then the extremes
    for (int o = 0; o < 8; o++) begin
      tw.op = 3'(o); tw.el = 16'sd3; tw.du = 15'd7; tw.cnt = 2'd3;
      tw.s = '{32'h8000_0000, 32'sd0, 32'h7fff_ffff};
      tw.t = '{32'h7fff_ffff, 32'sd65536, 32'h8000_0000};
      send_tween(tw);
      tw.el = 16'sd16383; tw.du = 15'd32767; send_tween(tw);
    end
    tw.el = 16'sd0;      tw.du = 15'd100;   send_tween(tw);
    tw.el = 16'sh8000;                      send_tween(tw);
    tw.el = 16'sd32767;  tw.du = 15'd32767; send_tween(tw);
    tw.el = 16'sd1;      tw.du = 15'd0;     send_tween(tw);
    tw.el = 16'sd32766;  tw.cnt = 2'd0;     send_tween(tw);
    tw.el = 16'sd1;      tw.cnt = 2'd1;     send_tween(tw);
    tw.cnt = 2'd2;                          send_tween(tw);
    // Random phases: no idling, sparse sender, receiver phase (never stalls), mixed
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      repeat (160) send_tween(random_tween());
    end
    start_i <= 1'b0;
    // Drain the pipeline
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (evi_pkg::LATENCY + 5) @(posedge clk_i);
    $display("Covered %0d transfers over all curves, edge timings and lane counts.",
      sb.checked);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/evi_pkg.sv
hdl/evi_divider.sv
hdl/evi_ease.sv
hdl/evi_lane.sv
hdl/eased_vector_interpolator_unit.sv
tb/sv/eased_vector_interpolator_unit_tb.sv
